FILE: rtl/ilid_pkg.sv
// Shared constants, codes and types for the indexed list block.
package ilid_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 3;
    localparam int POS_W      = 6;
    localparam int STAT_W     = 3;
    localparam int IPOS_W     = 5;
    localparam int FILL_W     = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_DUMP   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_BADPOS = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADCMD = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_INSERT = 3'd1,
        OP_UPDATE = 3'd2,
        OP_DELETE = 3'd3,
        OP_ROTATE = 3'd4
    } cell_op_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t         op;
        logic [CNT_W-1:0] pos;   // target index
        logic [CNT_W-1:0] tail;  // index of the last valid entry (rotate)
    } cell_ctrl_t;

endpackage

FILE: rtl/indexed_list_insert_delete.sv
// Top level of the indexed list: command decode, fill count, dump sequencer, result register.
//
//  channel   dir   handshake                     payload
//  command   in    start & !busy                 command, position, new_value
//  result    out   result_strobe (one cycle)     status, item_value, item_position,
//                                                fill_count, last_of_run
//
// Append, insert, update, delete, clear and error commands each give one result beat, the
// cycle after the command is taken, and busy stays low. A dump of N entries rotates the
// cell chain one place per cycle with busy high, sending the head cell on each of N beats;
// the first beat follows the state register entering the dump state and then the result
// register, and the list is back in order after the last one. rst_n clears the fill count
// and control; cell contents are only read below the fill count. The receiver cannot stall.
module indexed_list_insert_delete (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ilid_pkg::CMD_W-1:0]           command,
    input  logic [ilid_pkg::POS_W-1:0]           position,
    input  logic signed [ilid_pkg::DATA_W-1:0]   new_value,
    output logic                                 result_strobe,
    output logic [ilid_pkg::STAT_W-1:0]          status,
    output logic signed [ilid_pkg::DATA_W-1:0]   item_value,
    output logic [ilid_pkg::IPOS_W-1:0]          item_position,
    output logic [ilid_pkg::FILL_W-1:0]          fill_count,
    output logic                                 last_of_run
);
    import ilid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t                 state_reg,  state_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic [IDX_W-1:0]       dump_idx_reg, dump_idx_next;

    logic                   strobe_reg,   strobe_next;
    status_t                status_reg,   status_next;
    logic signed [DATA_W-1:0] value_reg,  value_next;
    logic [IPOS_W-1:0]      ipos_reg,     ipos_next;
    logic                   last_reg,     last_next;

    cell_ctrl_t             ctrl;
    logic signed [DATA_W-1:0] cell_value [LIST_DEPTH];
    logic signed [DATA_W-1:0] removed;
    logic [CNT_W-1:0]       pos_c;
    logic [CNT_W-1:0]       tail;
    logic                   accept;
    logic                   full;
    logic                   empty;

    assign accept = start && (state_reg == S_IDLE);
    assign pos_c  = CNT_W'(position);
    assign tail   = count_reg - CNT_W'(1);
    assign full   = (count_reg == CNT_W'(LIST_DEPTH));
    assign empty  = (count_reg == '0);

    // ---- cell chain ----
    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_v;
        logic signed [DATA_W-1:0] right_v;

        if (g == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_left
            assign left_v = cell_value[g-1];
        end

        if (g == LIST_DEPTH - 1)
        begin : g_end
            assign right_v = '0;
        end
        else
        begin : g_right
            assign right_v = cell_value[g+1];
        end

        ilid_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .index       (CNT_W'(g)),
            .left_value  (left_v),
            .right_value (right_v),
            .head_value  (cell_value[0]),
            .new_value   (new_value),
            .value       (cell_value[g])
        );
    end

    // word at the delete position, picked by an OR over the cells
    always_comb
    begin
        removed = '0;
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            if (CNT_W'(k) == pos_c)
            begin
                removed = removed | cell_value[k];
            end
        end
    end

    // ---- command decode and dump sequencing ----
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        strobe_next   = 1'b0;
        status_next   = ST_OK;
        value_next    = '0;
        ipos_next     = '0;
        last_next     = 1'b1;
        ctrl.op       = OP_HOLD;
        ctrl.pos      = pos_c;
        ctrl.tail     = tail;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    case (command)
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = OP_INSERT;
                                ctrl.pos   = count_reg;
                                count_next = count_reg + CNT_W'(1);
                                value_next = new_value;
                                ipos_next  = IPOS_W'(count_reg);
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_c > count_reg)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                ctrl.op    = OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                value_next = new_value;
                                ipos_next  = IPOS_W'(pos_c);
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_c >= count_reg)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                ctrl.op    = OP_UPDATE;
                                value_next = new_value;
                                ipos_next  = IPOS_W'(pos_c);
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_c >= count_reg)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                ctrl.op    = OP_DELETE;
                                count_next = tail;
                                value_next = removed;
                                ipos_next  = IPOS_W'(pos_c);
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // beats come from the dump state
                                strobe_next   = 1'b0;
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            // cells keep stale words; nothing reads past the count
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_BADCMD;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                strobe_next   = 1'b1;
                ctrl.op       = OP_ROTATE;
                value_next    = cell_value[0];
                ipos_next     = IPOS_W'(dump_idx_reg);
                last_next     = (CNT_W'(dump_idx_reg) == tail);
                dump_idx_next = dump_idx_reg + IDX_W'(1);
                if (last_next)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            dump_idx_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            strobe_reg   <= strobe_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        ipos_reg   <= ipos_next;
        last_reg   <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign item_value    = value_reg;
    assign item_position = ipos_reg;
    assign fill_count    = FILL_W'(count_reg);
    assign last_of_run   = last_reg;

endmodule

FILE: rtl/ilid_cell.sv
// One storage cell of the list chain: holds a word, takes it from a neighbor on shifts.
module ilid_cell (
    input  logic                                 clk,
    input  ilid_pkg::cell_ctrl_t                 ctrl,
    input  logic [ilid_pkg::CNT_W-1:0]           index,
    input  logic signed [ilid_pkg::DATA_W-1:0]   left_value,
    input  logic signed [ilid_pkg::DATA_W-1:0]   right_value,
    input  logic signed [ilid_pkg::DATA_W-1:0]   head_value,
    input  logic signed [ilid_pkg::DATA_W-1:0]   new_value,
    output logic signed [ilid_pkg::DATA_W-1:0]   value
);
    import ilid_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (index == ctrl.pos)
                begin
                    value_next = new_value;
                end
                else if (index > ctrl.pos)
                begin
                    value_next = left_value;
                end
            end
            OP_UPDATE:
            begin
                if (index == ctrl.pos)
                begin
                    value_next = new_value;
                end
            end
            OP_DELETE:
            begin
                if (index >= ctrl.pos)
                begin
                    value_next = right_value;
                end
            end
            OP_ROTATE:
            begin
                // tail takes the head; cells below it move down one
                if (index == ctrl.tail)
                begin
                    value_next = head_value;
                end
                else if (index < ctrl.tail)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: test/ilid_checker.sv
// Scoreboard for the indexed list: predicts every result beat and checks it as it arrives.
module ilid_checker
    import ilid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [CMD_W-1:0]          command,
    input  logic [POS_W-1:0]          position,
    input  logic signed [DATA_W-1:0]  new_value,
    input  logic                      result_strobe,
    input  logic [STAT_W-1:0]         status,
    input  logic signed [DATA_W-1:0]  item_value,
    input  logic [IPOS_W-1:0]         item_position,
    input  logic [FILL_W-1:0]         fill_count,
    input  logic                      last_of_run,
    output int                        mismatches,
    output int                        pending,
    output int                        list_fill,
    output int                        cmds_seen,
    output int                        beats_seen,
    output int                        full_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] value;
        logic [IPOS_W-1:0]        ipos;
        logic [FILL_W-1:0]        fill;
        logic                     last;
    } beat_t;

    logic signed [DATA_W-1:0] words [LIST_DEPTH];
    int                       count;
    beat_t                    beat_q[$];

    // fill field is taken from the count after the operation
    task automatic queue_beat(input status_t st, input logic signed [DATA_W-1:0] v,
                              input int p, input bit last);
        beat_t b;
        b.status = st;
        b.value  = v;
        b.ipos   = p[IPOS_W-1:0];
        b.fill   = count[FILL_W-1:0];
        b.last   = last;
        beat_q.push_back(b);
        if (st == ST_FULL)
            full_hits++;
    endtask

    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic signed [DATA_W-1:0] val);
        int                       p;
        logic signed [DATA_W-1:0] removed;
        p = int'(pos);
        case (cmd)
            CMD_APPEND:
                if (count >= LIST_DEPTH)
                    queue_beat(ST_FULL, '0, 0, 1'b1);
                else
                begin
                    words[count] = val;
                    count++;
                    queue_beat(ST_OK, val, count - 1, 1'b1);
                end
            CMD_INSERT:
                if (count >= LIST_DEPTH)
                    queue_beat(ST_FULL, '0, 0, 1'b1);
                else if (p > count)
                    queue_beat(ST_BADPOS, '0, 0, 1'b1);
                else
                begin
                    for (int i = count; i > p; i--)
                        words[i] = words[i-1];
                    words[p] = val;
                    count++;
                    queue_beat(ST_OK, val, p, 1'b1);
                end
            CMD_UPDATE:
                if (count == 0)
                    queue_beat(ST_EMPTY, '0, 0, 1'b1);
                else if (p >= count)
                    queue_beat(ST_BADPOS, '0, 0, 1'b1);
                else
                begin
                    words[p] = val;
                    queue_beat(ST_OK, val, p, 1'b1);
                end
            CMD_DELETE:
                if (count == 0)
                    queue_beat(ST_EMPTY, '0, 0, 1'b1);
                else if (p >= count)
                    queue_beat(ST_BADPOS, '0, 0, 1'b1);
                else
                begin
                    removed = words[p];
                    for (int i = p; i + 1 < count; i++)
                        words[i] = words[i+1];
                    count--;
                    queue_beat(ST_OK, removed, p, 1'b1);
                end
            CMD_DUMP:
                if (count == 0)
                    queue_beat(ST_EMPTY, '0, 0, 1'b1);
                else
                    for (int i = 0; i < count; i++)
                        queue_beat(ST_OK, words[i], i, i == count - 1);
            CMD_CLEAR:
            begin
                count = 0;
                queue_beat(ST_OK, '0, 0, 1'b1);
            end
            default:
                queue_beat(ST_BADCMD, '0, 0, 1'b1);
        endcase
    endtask

    task automatic flag_beat(input string what, input beat_t e, input beat_t a);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (what == "")
                $display("[%0t] beat mismatch: exp st=%0d val=%0d pos=%0d fill=%0d last=%0b",
                         $realtime, e.status, e.value, e.ipos, e.fill, e.last);
            else
                $display("[%0t] %s", $realtime, what);
            $display("           got  st=%0d val=%0d pos=%0d fill=%0d last=%0b",
                     a.status, a.value, a.ipos, a.fill, a.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t seen;
        beat_t want;
        if (!rst_n)
        begin
            beat_q.delete();
            count      = 0;
            mismatches = 0;
            cmds_seen  = 0;
            beats_seen = 0;
            full_hits  = 0;
        end
        else
        begin
            // result beats always belong to commands taken on earlier edges
            if (result_strobe)
            begin
                seen.status = status_t'(status);
                seen.value  = item_value;
                seen.ipos   = item_position;
                seen.fill   = fill_count;
                seen.last   = last_of_run;
                beats_seen++;
                if (beat_q.size() == 0)
                    flag_beat("result beat with nothing outstanding", '0, seen);
                else
                begin
                    want = beat_q.pop_front();
                    if (want !== seen)
                        flag_beat("", want, seen);
                end
            end
            if (start && !busy)
            begin
                cmds_seen++;
                apply_command(command, position, new_value);
            end
        end
        pending   = beat_q.size();
        list_fill = count;
    end

endmodule

FILE: test/tb_top.sv
// Top of the indexed list testbench: clock, reset, command stimulus and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ilid_pkg::*;

    // Random command beats after the directed part.
    localparam int RANDOM_ITEMS = 460;
    // Longest quiet stretch before the watchdog fires; well above any legal sender gap.
    localparam int WATCHDOG     = 500;
    // Settle time after the last beat, to catch stray beats.
    localparam int DRAIN        = 8;

    // Codes 6 and 7 have no member in cmd_t; they must come back as a bad command.
    localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

    typedef enum {EP_GROW, EP_CHURN, EP_SHRINK, EP_NOISE} episode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [CMD_W-1:0]          command;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  new_value;
    logic                      result_strobe;
    logic [STAT_W-1:0]         status;
    logic signed [DATA_W-1:0]  item_value;
    logic [IPOS_W-1:0]         item_position;
    logic [FILL_W-1:0]         fill_count;
    logic                      last_of_run;

    int mismatches;
    int pending;
    int list_fill;
    int cmds_seen;
    int beats_seen;
    int full_hits;

    int sent;          // command beats accepted by the current stimulus part
    bit no_idle;       // when set the sender runs back to back
    int quiet_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    indexed_list_insert_delete dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .position      (position),
        .new_value     (new_value),
        .result_strobe (result_strobe),
        .status        (status),
        .item_value    (item_value),
        .item_position (item_position),
        .fill_count    (fill_count),
        .last_of_run   (last_of_run)
    );

    ilid_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .position      (position),
        .new_value     (new_value),
        .result_strobe (result_strobe),
        .status        (status),
        .item_value    (item_value),
        .item_position (item_position),
        .fill_count    (fill_count),
        .last_of_run   (last_of_run),
        .mismatches    (mismatches),
        .pending       (pending),
        .list_fill     (list_fill),
        .cmds_seen     (cmds_seen),
        .beats_seen    (beats_seen),
        .full_hits     (full_hits)
    );

    // Watchdog: any taken command or result beat counts as progress. A hung
    // dump or a busy that never drops ends the run here.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // One command beat. Inputs only move on the falling edge; busy is read
    // on the rising edge, before the block updates it, so the beat is taken
    // exactly when the block sees start high and busy low. With no gap the
    // next beat follows without start ever dropping.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                         input logic signed [DATA_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     = 1'b1;
        command   = cmd;
        position  = pos;
        new_value = val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Data words: extremes show up often, the rest is uniform over 32 bits.
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One random command, shaped by the episode. Positions default to the
    // valid range for the current fill (from the checker's list model);
    // about one shaped beat in eight aims at or beyond the end.
    task automatic step(input episode_t ep);
        int               fill;
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        fill = list_fill;
        r    = $urandom_range(0, 99);
        pos  = (fill > 0) ? POS_W'($urandom_range(0, fill - 1)) : '0;
        case (ep)
            EP_GROW:
                if (r < 50)
                    cmd = CMD_APPEND;
                else if (r < 90)
                begin
                    cmd = CMD_INSERT;
                    pos = POS_W'($urandom_range(0, fill));
                end
                else
                    cmd = CMD_UPDATE;
            EP_SHRINK:
                if (r < 70)
                    cmd = CMD_DELETE;
                else if (r < 85)
                    cmd = CMD_UPDATE;
                else
                begin
                    cmd = CMD_INSERT;
                    pos = POS_W'($urandom_range(0, fill));
                end
            EP_CHURN:
                if (r < 20)
                    cmd = CMD_APPEND;
                else if (r < 40)
                begin
                    cmd = CMD_INSERT;
                    pos = POS_W'($urandom_range(0, fill));
                end
                else if (r < 60)
                    cmd = CMD_UPDATE;
                else if (r < 80)
                    cmd = CMD_DELETE;
                else if (r < 92)
                    cmd = CMD_DUMP;
                else
                    cmd = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
            default:
            begin
                // noise: command and position fully random
                cmd = CMD_W'($urandom_range(0, 2**CMD_W - 1));
                pos = POS_W'($urandom_range(0, 2**POS_W - 1));
            end
        endcase
        if (ep != EP_NOISE && $urandom_range(0, 7) == 0)
            pos = POS_W'($urandom_range(fill, 2**POS_W - 1));
        issue(cmd, pos, pick_word());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        command   = CMD_APPEND;
        position  = '0;
        new_value = '0;
        no_idle   = 1'b0;
        sent      = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: empty-list errors, edges of every position check,
        // insert at the end, first/last delete, both invalid codes, clear.
        issue(CMD_DUMP,   6'd0,          32'h0);          // dump of empty list
        issue(CMD_UPDATE, 6'd0,          32'h1234_5678);  // update on empty list
        issue(CMD_DELETE, 6'd0,          32'h0);          // delete on empty list
        issue(CMD_INSERT, 6'd1,          32'h1);          // insert past the end
        issue(CMD_INSERT, 6'd0,          32'h8000_0000);
        issue(CMD_APPEND, 6'd0,          32'h7FFF_FFFF);
        issue(CMD_APPEND, {POS_W{1'b1}}, 32'h0);
        issue(CMD_APPEND, 6'd0,          32'hFFFF_FFFF);
        issue(CMD_INSERT, {POS_W{1'b1}}, 32'h2);          // far past the end
        issue(CMD_INSERT, 6'd4,          32'h5A5A_5A5A);  // position == fill appends
        issue(CMD_UPDATE, 6'd5,          32'h3);          // update at fill
        issue(CMD_UPDATE, {POS_W{1'b1}}, 32'h4);
        issue(CMD_UPDATE, 6'd2,          32'hAAAA_AAAA);
        issue(CMD_INSERT, 6'd1,          32'h5555_5555);
        issue(CMD_DELETE, 6'd6,          32'h0);          // delete at fill
        issue(CMD_DELETE, 6'd5,          32'h0);          // last entry
        issue(CMD_DELETE, 6'd0,          32'h0);          // first entry
        issue(CMD_DELETE, {POS_W{1'b1}}, 32'h0);
        issue(CMD_DUMP,   6'd0,          32'h0);
        issue(CMD_BAD_LO, 6'd0,          32'h0);
        issue(CMD_BAD_HI, {POS_W{1'b1}}, 32'hFFFF_FFFF);
        issue(CMD_CLEAR,  6'd0,          32'h0);
        issue(CMD_DUMP,   6'd0,          32'h0);          // empty again after clear
        issue(CMD_APPEND, 6'd0,          32'h1);
        issue(CMD_DUMP,   6'd0,          32'h0);          // single-entry dump

        // Random part, in episodes. Grow runs to a full list and pushes a
        // few more beats into it, then dumps all 32; shrink drains to empty
        // and keeps going. Churn mixes every command but clear, noise ignores structure.
        // About a quarter of episodes run with no sender gaps.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    while (list_fill < LIST_DEPTH)
                        step(EP_GROW);
                    repeat (3) step(EP_GROW);
                    issue(CMD_DUMP, POS_W'($urandom_range(0, 2**POS_W - 1)), pick_word());
                end
                3, 4, 5:
                    repeat ($urandom_range(10, 30)) step(EP_CHURN);
                6, 7:
                begin
                    while (list_fill > 0)
                        step(EP_SHRINK);
                    repeat (3) step(EP_SHRINK);
                end
                8:
                    repeat ($urandom_range(5, 15)) step(EP_NOISE);
                default:
                    issue(CMD_CLEAR, POS_W'($urandom_range(0, 2**POS_W - 1)), pick_word());
            endcase
        end
        start = 1'b0;

        // Drain: wait for every predicted beat, then the DRAIN settle time so a
        // stray extra beat still gets flagged. The watchdog bounds the wait.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        $display("Run covered %0d commands and %0d result beats", cmds_seen, beats_seen);
        $display("including %0d rejects on a full list; %0d mismatches", full_hits, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ilid_pkg.sv
rtl/ilid_cell.sv
rtl/indexed_list_insert_delete.sv
test/ilid_checker.sv
test/tb_top.sv
